// ----- rtl/core/msdt_pkg.sv -----
// Shared constants, codes and types of the multi-slot deadline timer.
`timescale 1ns / 1ps
`default_nettype none

package msdt_pkg;

    // Slot table geometry
    localparam int SLOT_COUNT    = 8;
    localparam int RESERVED_SLOT = 0;
    localparam int SLOT_W        = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    // Field widths of the request and result items
    localparam int REQ_W      = 3;
    localparam int HANDLE_W   = 4;
    localparam int INTERVAL_W = 31;
    localparam int TICK_W     = 32;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 3'd0,
        REQ_RELEASE = 3'd1,
        REQ_START   = 3'd2,
        REQ_STOP    = 3'd3,
        REQ_SERVICE = 3'd4
    } req_t;

    // Result kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Shared adder result: raw sum and the clamped rearm delta
    typedef struct packed {
        logic [TICK_W-1:0]     sum;
        logic [INTERVAL_W-1:0] delta;
    } alu_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/msdt_alu.sv -----
// Shared 32-bit add/subtract unit with due-time clamp for the deadline timer.
`timescale 1ns / 1ps
`default_nettype none

module msdt_alu (
    input  wire msdt_pkg::alu_op_t              op,
    input  wire logic [msdt_pkg::TICK_W-1:0]    a,
    input  wire logic [msdt_pkg::TICK_W-1:0]    b,
    output msdt_pkg::alu_res_t                  res
);

    logic [msdt_pkg::TICK_W-1:0] sum;

    // Add or subtract modulo the tick range
    always_comb begin
        unique case (op)
            msdt_pkg::ALU_ADD: sum = a + b;
            msdt_pkg::ALU_SUB: sum = a - b;
            default:           sum = a + b;
        endcase
    end

    // Clamp a due or overdue distance to one tick
    always_comb begin
        res.sum = sum;
        if ((sum == '0) || sum[msdt_pkg::TICK_W-1]) begin
            res.delta = msdt_pkg::INTERVAL_W'(1);
        end else begin
            res.delta = sum[msdt_pkg::INTERVAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/multi_slot_deadline_timer.sv -----
// Top level of the multi-slot deadline timer: slot table, sequencer and result register.
//
//  channel | dir | tdata fields (low bit up)                    | tuser    | tlast
//  s_      | in  | slot[3:0] interval[34:4] repeat_req[35]      | req_type | -
//          |     | now[67:36]                                   |          |
//  m_      | out | fired_slot[3:0] ok[4] rearm_valid[5]         | kind     | last
//          |     | rearm_delta[36:6]                            |          |
//
// Steps: a request runs EXEC, the nearest-deadline scan and ACK; service first adds a due
// check over all slots, with a FIRE step for each due slot. The one shared adder visits one slot
// per cycle while no FIRE step stalls, once for the due check and once for the deadline scan.
// Reset: a synchronous aresetn low clears all slot marks; no clearing pass follows.
// Stalls: m_tready low holds a fire or acknowledgement step until the result register drains.
// s_tready is high only while the sequencer waits for a request.
`timescale 1ns / 1ps
`default_nettype none

module multi_slot_deadline_timer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // slot, interval, repeat_req, now
    input  wire logic [msdt_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  wire logic [msdt_pkg::REQ_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // fired_slot, ok, rearm_valid, rearm_delta
    output logic [msdt_pkg::OUT_DATA_W-1:0]         m_tdata,
    // kind
    output logic [0:0]                              m_tuser,
    output logic                                    m_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_DUE   = 6'b000100,
        ST_FIRE  = 6'b001000,
        ST_DELTA = 6'b010000,
        ST_ACK   = 6'b100000
    } state_t;

    localparam int SW = msdt_pkg::SLOT_W;
    localparam int HW = msdt_pkg::HANDLE_W;
    localparam int IW = msdt_pkg::INTERVAL_W;
    localparam int TW = msdt_pkg::TICK_W;

    state_t state_reg, state_next;
    logic [SW-1:0] idx_reg, idx_next;

    // Latched request
    msdt_pkg::req_t req_reg, req_next;
    logic [HW-1:0] slot_reg, slot_next;
    logic [IW-1:0] interval_reg, interval_next;
    logic          repeat_reg, repeat_next;
    logic [TW-1:0] now_reg, now_next;

    // Slot table
    logic [msdt_pkg::SLOT_COUNT-1:0] alloc_reg, alloc_next;
    logic [msdt_pkg::SLOT_COUNT-1:0] active_reg, active_next;
    logic [msdt_pkg::SLOT_COUNT-1:0] rep_reg, rep_next;
    logic [IW-1:0] ival_reg [msdt_pkg::SLOT_COUNT];
    logic [IW-1:0] ival_next [msdt_pkg::SLOT_COUNT];
    logic [TW-1:0] dline_reg [msdt_pkg::SLOT_COUNT];
    logic [TW-1:0] dline_next [msdt_pkg::SLOT_COUNT];

    // Acknowledgement bookkeeping
    logic          ok_reg, ok_next;
    logic [HW-1:0] ack_slot_reg, ack_slot_next;
    logic          any_reg, any_next;
    logic [IW-1:0] best_reg, best_next;

    // Result register
    logic          m_valid_reg, m_valid_next;
    logic          m_kind_reg, m_kind_next;
    logic [HW-1:0] m_slot_reg, m_slot_next;
    logic          m_ok_reg, m_ok_next;
    logic          m_rv_reg, m_rv_next;
    logic [IW-1:0] m_delta_reg, m_delta_next;
    logic          m_last_reg, m_last_next;

    msdt_pkg::alu_op_t  alu_op;
    logic [TW-1:0]      alu_a;
    logic [TW-1:0]      alu_b;
    msdt_pkg::alu_res_t alu_res;

    logic          s_fire;
    logic          out_free;
    logic          in_range;
    logic [SW-1:0] wr_idx;
    logic          alloc_found;
    logic [SW-1:0] alloc_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign in_range = ({1'b0, slot_reg} < (HW + 1)'(msdt_pkg::SLOT_COUNT));
    assign wr_idx   = slot_reg[SW-1:0];

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {3'b000, m_delta_reg, m_rv_reg, m_ok_reg, m_slot_reg};
    assign m_tuser[0] = m_kind_reg;
    assign m_tlast    = m_last_reg;

    // Find the first free slot above the reserved one
    always_comb begin
        alloc_found = 1'b0;
        alloc_idx   = '0;
        for (int i = 0; i < msdt_pkg::SLOT_COUNT; i++) begin
            if ((i > msdt_pkg::RESERVED_SLOT) && !alloc_reg[i] && !alloc_found) begin
                alloc_found = 1'b1;
                alloc_idx   = SW'(i);
            end
        end
    end

    // Steer the shared adder by sequencer step
    always_comb begin
        unique case (state_reg)
            ST_EXEC: begin
                alu_op = msdt_pkg::ALU_ADD;
                alu_a  = now_reg;
                alu_b  = {1'b0, interval_reg};
            end
            ST_DUE: begin
                alu_op = msdt_pkg::ALU_SUB;
                alu_a  = now_reg;
                alu_b  = dline_reg[idx_reg];
            end
            ST_FIRE: begin
                alu_op = msdt_pkg::ALU_ADD;
                alu_a  = dline_reg[idx_reg];
                alu_b  = {1'b0, ival_reg[idx_reg]};
            end
            default: begin
                alu_op = msdt_pkg::ALU_SUB;
                alu_a  = dline_reg[idx_reg];
                alu_b  = now_reg;
            end
        endcase
    end

    msdt_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // Sequencer and table update
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        slot_next     = slot_reg;
        interval_next = interval_reg;
        repeat_next   = repeat_reg;
        now_next      = now_reg;
        alloc_next    = alloc_reg;
        active_next   = active_reg;
        rep_next      = rep_reg;
        ival_next     = ival_reg;
        dline_next    = dline_reg;
        ok_next       = ok_reg;
        ack_slot_next = ack_slot_reg;
        any_next      = any_reg;
        best_next     = best_reg;

        // Drop the held result once taken
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_slot_next  = m_slot_reg;
        m_ok_next    = m_ok_reg;
        m_rv_next    = m_rv_reg;
        m_delta_next = m_delta_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next      = msdt_pkg::req_t'(s_tuser);
                    slot_next     = s_tdata[3:0];
                    interval_next = s_tdata[34:4];
                    repeat_next   = s_tdata[35];
                    now_next      = s_tdata[67:36];
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ok_next       = 1'b0;
                ack_slot_next = '0;
                any_next      = 1'b0;
                best_next     = '0;
                idx_next      = '0;
                state_next    = ST_DELTA;
                unique case (req_reg)
                    msdt_pkg::REQ_ALLOC: begin
                        if (alloc_found) begin
                            alloc_next[alloc_idx] = 1'b1;
                            ack_slot_next         = HW'(alloc_idx);
                            ok_next               = 1'b1;
                        end
                    end
                    msdt_pkg::REQ_RELEASE: begin
                        if (in_range) begin
                            active_next[wr_idx] = 1'b0;
                            alloc_next[wr_idx]  = 1'b0;
                            ok_next             = 1'b1;
                        end
                    end
                    msdt_pkg::REQ_START: begin
                        if (in_range && (interval_reg != '0)) begin
                            ival_next[wr_idx]   = interval_reg;
                            dline_next[wr_idx]  = alu_res.sum;
                            rep_next[wr_idx]    = repeat_reg;
                            active_next[wr_idx] = 1'b1;
                            ok_next             = 1'b1;
                        end
                    end
                    msdt_pkg::REQ_STOP: begin
                        if (in_range) begin
                            active_next[wr_idx] = 1'b0;
                            ok_next             = 1'b1;
                        end
                    end
                    msdt_pkg::REQ_SERVICE: begin
                        ok_next    = 1'b1;
                        state_next = ST_DUE;
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ST_DUE: begin
                // Fire when now has reached the deadline
                if (active_reg[idx_reg] && !alu_res.sum[TW-1]) begin
                    state_next = ST_FIRE;
                end else if (idx_reg == msdt_pkg::SLOT_LAST) begin
                    idx_next   = '0;
                    state_next = ST_DELTA;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FIRE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = msdt_pkg::KIND_FIRE;
                    m_slot_next  = HW'(idx_reg);
                    m_ok_next    = 1'b1;
                    m_rv_next    = 1'b0;
                    m_delta_next = '0;
                    m_last_next  = 1'b0;
                    // Reload a periodic slot, retire a one-shot slot
                    if (rep_reg[idx_reg]) begin
                        dline_next[idx_reg] = alu_res.sum;
                    end else begin
                        active_next[idx_reg] = 1'b0;
                    end
                    if (idx_reg == msdt_pkg::SLOT_LAST) begin
                        idx_next   = '0;
                        state_next = ST_DELTA;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DUE;
                    end
                end
            end
            ST_DELTA: begin
                // Keep the nearest active deadline
                if (active_reg[idx_reg] && (!any_reg || (alu_res.delta < best_reg))) begin
                    any_next  = 1'b1;
                    best_next = alu_res.delta;
                end
                if (idx_reg == msdt_pkg::SLOT_LAST) begin
                    state_next = ST_ACK;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = msdt_pkg::KIND_ACK;
                    m_slot_next  = ack_slot_reg;
                    m_ok_next    = ok_reg;
                    m_rv_next    = any_reg;
                    m_delta_next = best_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            alloc_reg   <= '0;
            active_reg  <= '0;
            rep_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            alloc_reg   <= alloc_next;
            active_reg  <= active_next;
            rep_reg     <= rep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        req_reg      <= req_next;
        slot_reg     <= slot_next;
        interval_reg <= interval_next;
        repeat_reg   <= repeat_next;
        now_reg      <= now_next;
        ival_reg     <= ival_next;
        dline_reg    <= dline_next;
        ok_reg       <= ok_next;
        ack_slot_reg <= ack_slot_next;
        any_reg      <= any_next;
        best_reg     <= best_next;
        m_kind_reg   <= m_kind_next;
        m_slot_reg   <= m_slot_next;
        m_ok_reg     <= m_ok_next;
        m_rv_reg     <= m_rv_next;
        m_delta_reg  <= m_delta_next;
        m_last_reg   <= m_last_next;
    end

    // A taken request closes the input until its acknowledgement is queued
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("input open right after a request");

    // Fire results are never last, acknowledgements always are
    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] != m_tlast))
        else $error("kind and last disagree");

    // Rearm delta is nonzero exactly when a countdown is armed
    a_rearm_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5] == (m_tdata[36:6] != '0)))
        else $error("rearm delta and rearm valid disagree");

    // A slot chosen for firing stays active until its result is queued
    a_fire_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIRE) |-> active_reg[idx_reg])
        else $error("firing an inactive slot");

    // Back at idle, only an acknowledgement can still wait
    a_idle_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) && m_tvalid) |-> m_tlast)
        else $error("fire result pending at idle");

endmodule

`default_nettype wire

// ----- test/multi_slot_deadline_timer_tb.sv -----
// Self-checking testbench of the multi-slot deadline timer: driver, monitor, table predictor.
`timescale 1ns / 1ps

module multi_slot_deadline_timer_tb;

    // Request codes the block does not know
    localparam logic [msdt_pkg::REQ_W-1:0] REQ_UNDEF_FIRST = 3'd5;
    localparam logic [msdt_pkg::REQ_W-1:0] REQ_UNDEF_LAST  = 3'd7;

    localparam int RANDOM_REQS  = 400;
    localparam int TAIL_REQS    = 40;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AFTER   = 80;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [msdt_pkg::REQ_W-1:0]      req;
        logic [msdt_pkg::HANDLE_W-1:0]   slot;
        logic [msdt_pkg::INTERVAL_W-1:0] interval;
        logic                            rep;
        logic [msdt_pkg::TICK_W-1:0]     now;
    } timer_req_t;

    typedef struct {
        logic                            kind;
        logic [msdt_pkg::HANDLE_W-1:0]   fired_slot;
        logic                            ok;
        logic                            rearm_valid;
        logic [msdt_pkg::INTERVAL_W-1:0] rearm_delta;
        logic                            last;
    } timer_res_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [msdt_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [msdt_pkg::REQ_W-1:0]      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [msdt_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;
    logic                            m_tlast;

    multi_slot_deadline_timer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predicted copy of the slot table
    logic                            tbl_alloc    [msdt_pkg::SLOT_COUNT];
    logic                            tbl_active   [msdt_pkg::SLOT_COUNT];
    logic                            tbl_repeat   [msdt_pkg::SLOT_COUNT];
    logic [msdt_pkg::INTERVAL_W-1:0] tbl_interval [msdt_pkg::SLOT_COUNT];
    logic [msdt_pkg::TICK_W-1:0]     tbl_deadline [msdt_pkg::SLOT_COUNT];

    timer_req_t request_backlog[$];
    timer_res_t awaited_results[$];
    timer_req_t offered_req;

    int requests_total    = 0;
    int requests_accepted = 0;
    int results_checked   = 0;
    int errors            = 0;
    int gap_left          = 0;
    int stall_left        = 0;
    int hold_left         = 0;
    bit hold_done         = 1'b0;
    int idle_cycles       = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Apply one request to the predicted table and queue the results it causes
    task automatic timer_table_step(input timer_req_t rq);
        timer_res_t                    r;
        logic [msdt_pkg::HANDLE_W-1:0] grant;
        logic                          ok;
        logic                          any;
        logic                          in_range;
        logic [msdt_pkg::TICK_W-1:0]   d;
        logic [msdt_pkg::TICK_W-1:0]   best;
        int                            i;
        grant    = '0;
        ok       = 1'b0;
        in_range = rq.slot < msdt_pkg::SLOT_COUNT;
        case (rq.req)
            msdt_pkg::REQ_ALLOC: begin
                for (i = msdt_pkg::RESERVED_SLOT + 1; i < msdt_pkg::SLOT_COUNT; i++) begin
                    if (!ok && !tbl_alloc[i]) begin
                        tbl_alloc[i] = 1'b1;
                        grant        = msdt_pkg::HANDLE_W'(i);
                        ok           = 1'b1;
                    end
                end
            end
            msdt_pkg::REQ_RELEASE: begin
                if (in_range) begin
                    tbl_active[rq.slot] = 1'b0;
                    tbl_alloc[rq.slot]  = 1'b0;
                    ok                  = 1'b1;
                end
            end
            msdt_pkg::REQ_START: begin
                if (in_range && rq.interval != '0) begin
                    tbl_interval[rq.slot] = rq.interval;
                    tbl_deadline[rq.slot] = rq.now + {1'b0, rq.interval};
                    tbl_repeat[rq.slot]   = rq.rep;
                    tbl_active[rq.slot]   = 1'b1;
                    ok                    = 1'b1;
                end
            end
            msdt_pkg::REQ_STOP: begin
                if (in_range) begin
                    tbl_active[rq.slot] = 1'b0;
                    ok                  = 1'b1;
                end
            end
            msdt_pkg::REQ_SERVICE: begin
                // fire every due slot in index order
                for (i = 0; i < msdt_pkg::SLOT_COUNT; i++) begin
                    d = rq.now - tbl_deadline[i];
                    if (tbl_active[i] && !d[msdt_pkg::TICK_W-1]) begin
                        if (tbl_repeat[i])
                            tbl_deadline[i] = tbl_deadline[i] + {1'b0, tbl_interval[i]};
                        else
                            tbl_active[i] = 1'b0;
                        r.kind        = msdt_pkg::KIND_FIRE;
                        r.fired_slot  = msdt_pkg::HANDLE_W'(i);
                        r.ok          = 1'b1;
                        r.rearm_valid = 1'b0;
                        r.rearm_delta = '0;
                        r.last        = 1'b0;
                        awaited_results.push_back(r);
                    end
                end
                ok = 1'b1;
            end
            default: ;
        endcase

        // nearest deadline, due or overdue counts as one tick
        any  = 1'b0;
        best = '0;
        for (i = 0; i < msdt_pkg::SLOT_COUNT; i++) begin
            if (tbl_active[i]) begin
                d = tbl_deadline[i] - rq.now;
                if (d == '0 || d[msdt_pkg::TICK_W-1])
                    d = 1;
                if (!any || d < best) begin
                    best = d;
                    any  = 1'b1;
                end
            end
        end
        r.kind        = msdt_pkg::KIND_ACK;
        r.fired_slot  = grant;
        r.ok          = ok;
        r.rearm_valid = any;
        r.rearm_delta = best[msdt_pkg::INTERVAL_W-1:0];
        r.last        = 1'b1;
        awaited_results.push_back(r);
    endtask

    task automatic queue_request(input logic [msdt_pkg::REQ_W-1:0] req,
                                 input logic [msdt_pkg::HANDLE_W-1:0] slot,
                                 input logic [msdt_pkg::INTERVAL_W-1:0] interval,
                                 input logic rep,
                                 input logic [msdt_pkg::TICK_W-1:0] now);
        timer_req_t rq;
        rq.req      = req;
        rq.slot     = slot;
        rq.interval = interval;
        rq.rep      = rep;
        rq.now      = now;
        request_backlog.push_back(rq);
        requests_total++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: mismatch on %s: expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Driver: offer queued requests, predict on each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                timer_table_step(offered_req);
                requests_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_backlog.size() > TAIL_REQS && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 17);
                    s_tvalid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    offered_req = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, offered_req.now, offered_req.rep,
                                 offered_req.interval, offered_req.slot};
                    s_tuser  <= offered_req.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once results are flowing
    always @(posedge aclk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && results_checked >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: compare each result with the oldest prediction, stall at random
    always @(posedge aclk) begin
        timer_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: extra result: expected none, actual %0h kind %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("kind",        32'(want.kind),        32'(m_tuser[0]));
                    check_field("fired_slot",  32'(want.fired_slot),  32'(m_tdata[3:0]));
                    check_field("ok",          32'(want.ok),          32'(m_tdata[4]));
                    check_field("rearm_valid", 32'(want.rearm_valid), 32'(m_tdata[5]));
                    check_field("rearm_delta", 32'(want.rearm_delta), 32'(m_tdata[36:6]));
                    check_field("last",        32'(want.last),        32'(m_tlast));
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (request_backlog.size() > TAIL_REQS && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("multi_slot_deadline_timer_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [msdt_pkg::TICK_W-1:0]     tick;
        logic [msdt_pkg::REQ_W-1:0]      req;
        logic [msdt_pkg::HANDLE_W-1:0]   slot;
        logic [msdt_pkg::INTERVAL_W-1:0] interval;
        int                              pick;
        int                              n;

        for (n = 0; n < msdt_pkg::SLOT_COUNT; n++) begin
            tbl_alloc[n]    = 1'b0;
            tbl_active[n]   = 1'b0;
            tbl_repeat[n]   = 1'b0;
            tbl_interval[n] = '0;
            tbl_deadline[n] = '0;
        end

        // Directed: empty service, allocate until full, rejects, wrap, mass fire
        tick = 32'hFFFF_FFF0;
        queue_request(msdt_pkg::REQ_SERVICE, 4'd0, '0, 1'b0, tick);
        for (n = 0; n < msdt_pkg::SLOT_COUNT; n++)
            queue_request(msdt_pkg::REQ_ALLOC, 4'hF, 31'h7FFF_FFFF, 1'b1, tick);
        queue_request(msdt_pkg::REQ_START, 4'd0, 31'd1, 1'b1, tick);
        queue_request(msdt_pkg::REQ_START, 4'd7, 31'h7FFF_FFFF, 1'b0, tick);
        queue_request(msdt_pkg::REQ_START, 4'd3, '0, 1'b1, tick);
        queue_request(msdt_pkg::REQ_START, 4'hF, 31'd5, 1'b1, tick);
        queue_request(msdt_pkg::REQ_RELEASE, 4'd8, 31'd9, 1'b0, tick);
        queue_request(msdt_pkg::REQ_STOP, 4'hF, '0, 1'b1, tick);
        queue_request(REQ_UNDEF_FIRST, 4'd1, 31'd4, 1'b1, tick);
        queue_request(REQ_UNDEF_LAST, 4'd2, 31'd4, 1'b0, tick);
        for (n = 1; n < msdt_pkg::SLOT_COUNT; n++) begin
            tick = tick + 1;
            queue_request(msdt_pkg::REQ_START, 4'(n), 31'(3 * n), 1'(n), tick);
        end
        tick = tick + 200;
        queue_request(msdt_pkg::REQ_SERVICE, 4'd0, '0, 1'b0, tick);
        queue_request(msdt_pkg::REQ_STOP, 4'd1, '0, 1'b0, tick);
        queue_request(msdt_pkg::REQ_RELEASE, 4'd2, '0, 1'b0, tick);
        // reloaded slot zero is still overdue and fires again
        queue_request(msdt_pkg::REQ_SERVICE, 4'd0, '0, 1'b0, tick);

        // Random: mostly steady tick advance with short intervals, some jumps
        tick = $urandom;
        for (n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15)      req = msdt_pkg::REQ_ALLOC;
            else if (pick < 30) req = msdt_pkg::REQ_RELEASE;
            else if (pick < 60) req = msdt_pkg::REQ_START;
            else if (pick < 70) req = msdt_pkg::REQ_STOP;
            else if (pick < 95) req = msdt_pkg::REQ_SERVICE;
            else                req = 3'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
            if ($urandom_range(0, 99) < 85)
                slot = 4'($urandom_range(0, msdt_pkg::SLOT_COUNT - 1));
            else
                slot = 4'($urandom_range(msdt_pkg::SLOT_COUNT, 15));
            pick = $urandom_range(0, 99);
            if (pick < 70)      interval = 31'($urandom_range(1, 40));
            else if (pick < 80) interval = 31'($urandom_range(1, 2));
            else if (pick < 90) interval = 31'($urandom);
            else if (pick < 95) interval = '0;
            else                interval = 31'h7FFF_FFFF;
            if ($urandom_range(0, 39) == 0)
                tick = $urandom;
            else
                tick = tick + $urandom_range(0, 12);
            queue_request(req, slot, interval, 1'($urandom), tick);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (requests_accepted < requests_total || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("multi_slot_deadline_timer_tb: PASS");
        else
            $display("multi_slot_deadline_timer_tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/msdt_pkg.sv
rtl/core/msdt_alu.sv
rtl/core/multi_slot_deadline_timer.sv
test/multi_slot_deadline_timer_tb.sv
